// ===== rtl/binary_to_decimal_ascii_core_assert.svh =====
// assertion macros for the binary to decimal ascii core
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`ifndef SYNTH
`define B2DA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b2da: implication check failed");
`define B2DA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b2da: next cycle check failed");
`else
`define B2DA_ASSERT_IMP(lbl, ante, cons)
`define B2DA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/b2da_pkg.sv =====
// shared types and constants for the binary to decimal ascii core
`timescale 1ns / 1ps
package b2da_pkg;

	localparam int VALUE_W    = 31;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
	localparam int ASCII_W    = 6;

	localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// top level: binary value in, decimal ascii digits out, most significant first
//
// input channel: value with in_valid / in_stall; a word is taken when in_valid
// is high and in_stall is low. in_stall stays high from the accepted word until
// its last digit has been taken, so one value is converted at a time.
// output channel: ascii_digit and last with out_valid / out_stall; one word per
// decimal digit, leading zeros dropped, last high on the final digit. zero
// gives the single digit '0'.
// steps: the double dabble unit shifts one input bit per cycle, then the bcd
// is handed over, leading zero digits are dropped one per cycle, a final skip
// step finds the first digit and digits are sent one per cycle unless
// out_stall is high. with no output stall the time from one accept to the
// next is the same for any number of digits.
// out_stall holds the current digit in place and only delays the block.
// arst_n returns the block to idle, ready for a value, with no output pending.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_core_assert.svh"
module binary_to_decimal_ascii_core
	import b2da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ASCII_W-1:0] ascii_digit,
	output logic               last
);

	state_t              state_q;
	state_t              state_d;
	logic [BCD_W-1:0]    bcd_q;
	logic [LEFT_W-1:0]   left_q;
	logic [BCD_W-1:0]    conv_bcd;
	logic                conv_done;
	logic                in_acc;
	logic                skip_go;
	logic                on_last;
	logic [DIGIT_W-1:0]  top_digit;

	assign in_acc    = in_valid && !in_stall;
	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign on_last   = (left_q == LEFT_W'(1));
	assign skip_go   = (top_digit == '0) && !on_last;

	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.value  (value),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_go) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_stall && on_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		out_valid   = (state_q == ST_EMIT);
		ascii_digit = ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, top_digit};
		last        = on_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CONV: if (conv_done) left_q <= LEFT_W'(NUM_DIGITS);
				ST_SKIP: if (skip_go) left_q <= left_q - 1'b1;
				ST_EMIT: if (!out_stall) left_q <= left_q - 1'b1;
				default: left_q <= left_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CONV: if (conv_done) bcd_q <= conv_bcd;
			ST_SKIP: if (skip_go) bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			ST_EMIT: if (!out_stall) bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			default: bcd_q <= bcd_q;
		endcase
	end

	`B2DA_ASSERT_IMP(a_digit_range, out_valid, ascii_digit >= ASCII_ZERO && ascii_digit <= 6'd57)
	`B2DA_ASSERT_NXT(a_no_early_out, in_acc, !out_valid && in_stall)
	`B2DA_ASSERT_NXT(a_idle_after_last, out_valid && last && !out_stall, !out_valid && !in_stall)
	`B2DA_ASSERT_IMP(a_done_in_conv, conv_done, state_q == ST_CONV)

endmodule

// ===== rtl/b2da_dabble.sv =====
// bit-serial double dabble converter, one input bit per cycle
`timescale 1ns / 1ps
module b2da_dabble
	import b2da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	output logic               done,
	output logic [BCD_W-1:0]   bcd
);

	localparam int CNT_W = $clog2(VALUE_W + 1);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
